// ===== design/pmft_pkg.sv =====
// ----------------------------------------------------------------------------
// pmft_pkg
// shared types and codes for the polygon mutual facing test block
// ----------------------------------------------------------------------------
`default_nettype none

package pmft_pkg;

  // request codes of the input beat
  typedef enum logic [2:0] {
    REQ_NORMAL_I = 3'd0,
    REQ_NORMAL_J = 3'd1,
    REQ_VERT_I   = 3'd2,
    REQ_VERT_J   = 3'd3,
    REQ_EVAL     = 3'd4
  } req_t;

  localparam int COORD_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // load beat accepted
    logic start;   // evaluate accepted, rewind pair walk
    logic diff;    // form r = vj - vi
    logic mul;     // component products
    logic sum;     // sum, sign test, step to next pair
    logic finish;  // load result register, clear counts
  } pmft_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // a polygon holds no vertex
    logic pair_vis;   // current pair faces both ways
    logic last_pair;  // current pair is the last one
  } pmft_sts_t;

endpackage

`default_nettype wire

// ===== design/pmft_if.sv =====
// ----------------------------------------------------------------------------
// pmft channel interfaces
// valid/ready channels for request and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface pmft_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface pmft_out_if;
  logic valid;
  logic ready;
  logic culled;
  logic overflowed;

  modport source (output valid, culled, overflowed, input ready);
  modport sink   (input valid, culled, overflowed, output ready);
endinterface

`default_nettype wire

// ===== design/pmft_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmft_ctrl
// sequencer for loads, the vertex pair walk and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module pmft_ctrl
  import pmft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_req_type,
  input  wire logic       out_ready,
  input  wire pmft_sts_t  sts,
  output pmft_cmd_t       cmd,
  output logic            in_ready,
  output logic            out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   is_eval;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept   = in_valid && in_ready;
  assign is_eval  = (in_req_type == REQ_EVAL);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_eval) begin
            cmd.start = 1'b1;
            state_nxt = sts.empty ? S_DONE : S_DIFF;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = (sts.pair_vis || sts.last_pair) ? S_DONE : S_DIFF;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pmft_dp.sv =====
// ----------------------------------------------------------------------------
// pmft_dp
// normals, vertex stores, pair walk indices and exact dot product signs
// ----------------------------------------------------------------------------
`default_nettype none

module pmft_dp
  import pmft_pkg::*;
#(
  parameter int MAX_VERTS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pmft_cmd_t  cmd,
  input  wire logic [2:0] in_req_type,
  input  wire coord_t     in_coord_x,
  input  wire coord_t     in_coord_y,
  input  wire coord_t     in_coord_z,
  output pmft_sts_t       sts,
  output logic            culled,
  output logic            overflowed
);

  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int IW = $clog2(MAX_VERTS);
  localparam int RW = COORD_W + 1;          // vertex difference
  localparam int PW = RW + COORD_W;         // component product
  localparam int SW = PW + 2;               // three-term sum

  vec3_t nrm_i_r, nrm_j_r;
  vec3_t verts_i_r [MAX_VERTS];
  vec3_t verts_j_r [MAX_VERTS];
  logic [CW-1:0] count_i_r, count_j_r;
  logic          drop_r;
  logic [IW-1:0] m_r, n_r;
  logic          vis_r;
  logic          culled_r, overflowed_r;

  logic signed [RW-1:0] r_r [3];
  logic signed [PW-1:0] pi_r [3];
  logic signed [PW-1:0] pj_r [3];
  logic signed [SW-1:0] dot_i, dot_j;

  vec3_t in_vec;
  vec3_t vi, vj;
  coord_t ni [3];
  coord_t nj [3];
  logic  last_m, last_n;

  assign in_vec = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
  assign vi     = verts_i_r[m_r];
  assign vj     = verts_j_r[n_r];
  assign ni     = '{nrm_i_r.x, nrm_i_r.y, nrm_i_r.z};
  assign nj     = '{nrm_j_r.x, nrm_j_r.y, nrm_j_r.z};

  assign last_m = (CW'(m_r) == (count_i_r - CW'(1)));
  assign last_n = (CW'(n_r) == (count_j_r - CW'(1)));

  // exact sums, products sign extended by two bits
  assign dot_i = {{2{pi_r[0][PW-1]}}, pi_r[0]} + {{2{pi_r[1][PW-1]}}, pi_r[1]}
               + {{2{pi_r[2][PW-1]}}, pi_r[2]};
  assign dot_j = {{2{pj_r[0][PW-1]}}, pj_r[0]} + {{2{pj_r[1][PW-1]}}, pj_r[1]}
               + {{2{pj_r[2][PW-1]}}, pj_r[2]};

  assign sts.empty     = (count_i_r == '0) || (count_j_r == '0);
  assign sts.pair_vis  = (!dot_i[SW-1] && (dot_i != '0)) && dot_j[SW-1];
  assign sts.last_pair = last_m && last_n;

  assign culled     = culled_r;
  assign overflowed = overflowed_r;

  // control state: normals, counts, drop flag, walk indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_i_r   <= '0;
      nrm_j_r   <= '0;
      count_i_r <= '0;
      count_j_r <= '0;
      drop_r    <= 1'b0;
      m_r       <= '0;
      n_r       <= '0;
      vis_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        unique case (in_req_type)
          REQ_NORMAL_I: nrm_i_r <= in_vec;
          REQ_NORMAL_J: nrm_j_r <= in_vec;
          REQ_VERT_I: begin
            if (count_i_r < CW'(MAX_VERTS)) count_i_r <= count_i_r + CW'(1);
            else drop_r <= 1'b1;
          end
          REQ_VERT_J: begin
            if (count_j_r < CW'(MAX_VERTS)) count_j_r <= count_j_r + CW'(1);
            else drop_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.start) begin
        m_r   <= '0;
        n_r   <= '0;
        vis_r <= 1'b0;
      end
      if (cmd.sum) begin
        vis_r <= sts.pair_vis;
        if (last_n) begin
          n_r <= '0;
          m_r <= m_r + IW'(1);
        end else begin
          n_r <= n_r + IW'(1);
        end
      end
      if (cmd.finish) begin
        count_i_r <= '0;
        count_j_r <= '0;
        drop_r    <= 1'b0;
      end
    end
  end

  // payload: vertex stores, pipeline terms, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (in_req_type)
        REQ_VERT_I: begin
          if (count_i_r < CW'(MAX_VERTS)) verts_i_r[count_i_r[IW-1:0]] <= in_vec;
        end
        REQ_VERT_J: begin
          if (count_j_r < CW'(MAX_VERTS)) verts_j_r[count_j_r[IW-1:0]] <= in_vec;
        end
        default: ;
      endcase
    end
    if (cmd.diff) begin
      r_r[0] <= {vj.x[COORD_W-1], vj.x} - {vi.x[COORD_W-1], vi.x};
      r_r[1] <= {vj.y[COORD_W-1], vj.y} - {vi.y[COORD_W-1], vi.y};
      r_r[2] <= {vj.z[COORD_W-1], vj.z} - {vi.z[COORD_W-1], vi.z};
    end
    if (cmd.mul) begin
      for (int k = 0; k < 3; k++) begin
        pi_r[k] <= PW'(r_r[k] * ni[k]);
        pj_r[k] <= PW'(r_r[k] * nj[k]);
      end
    end
    if (cmd.finish) begin
      culled_r     <= !vis_r;
      overflowed_r <= drop_r;
    end
  end

endmodule

`default_nettype wire

// ===== design/polygon_mutual_facing_test_top.sv =====
// ----------------------------------------------------------------------------
// polygon_mutual_facing_test_top
// back face test of a polygon pair over all vertex pairs, exact fixed point
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                               handshake
//   in_ch    in   req_type, coord_x, coord_y, coord_z   valid/ready
//   out_ch   out  culled, overflowed                    valid/ready
//
// - a load beat (normal or vertex) keeps the block idle; the next beat may follow
// - evaluate walks vertex pairs through the diff, mul and sum states, then waits in
//   done until the result register is free; the walk stops at the first visible pair
// - the pair walk runs one shared difference/multiply/sum path, one pair at a time
// - reset clears counts, drop flag and both normals
// - a waiting result does not block loads; only the next result write waits on it
//
`default_nettype none

module polygon_mutual_facing_test_top
  import pmft_pkg::*;
#(
  parameter int MAX_VERTS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pmft_in_if.sink   in_ch,
  pmft_out_if.source out_ch
);

  pmft_cmd_t cmd;
  pmft_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  logic      culled;
  logic      overflowed;

  // handshake sits on the controller, payload on the datapath
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.culled     = culled;
  assign out_ch.overflowed = overflowed;

  // sequencer: load decode, pair walk steps, result register valid
  pmft_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd),
    .in_ready    (in_ready),
    .out_valid   (out_valid)
  );

  // storage and arithmetic: r = vj - vi, r.ni > 0 and r.nj < 0
  pmft_dp #(
    .MAX_VERTS (MAX_VERTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_req_type (in_ch.req_type),
    .in_coord_x  (in_ch.coord_x),
    .in_coord_y  (in_ch.coord_y),
    .in_coord_z  (in_ch.coord_z),
    .sts         (sts),
    .culled      (culled),
    .overflowed  (overflowed)
  );

endmodule

`default_nettype wire

// ===== design/pmft_checker.sv =====
// ----------------------------------------------------------------------------
// pmft_checker
// port level checks for the polygon mutual facing test block
// ----------------------------------------------------------------------------
`default_nettype none

module pmft_checker
  import pmft_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_req_type,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       culled,
  input wire logic       overflowed
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(culled) && $stable(overflowed))
    else $error("result payload changed while stalled");

  // a load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type != REQ_EVAL) |=> !$rose(out_valid))
    else $error("result beat after a load");

  // evaluate occupies the block for at least the following cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type == REQ_EVAL) |=> !in_ready)
    else $error("request taken during evaluate");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind polygon_mutual_facing_test_top pmft_checker u_pmft_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .culled      (out_ch.culled),
  .overflowed  (out_ch.overflowed)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// polygon mutual facing test bench
// drives load and evaluate beats into the block under random idling, predicts
// each culled/overflowed verdict with exact wide sign arithmetic, checks every
// result beat in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pmft_pkg::*;

  localparam int MAX_VERTS = 4;
  localparam int ITEM_GOAL = 1575;          // directed beats plus about 1550 random
  localparam int DRAIN_CYCLES = 3 * MAX_VERTS * MAX_VERTS + 20;
  localparam int LONG_HOLD = 400;           // receiver back-pressure stretch
  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  // one expected result beat
  typedef struct packed {
    logic culled;
    logic overflowed;
  } verdict_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of normals, vertex stores, counts and drop flag
  // --------------------------------------------------------------------------
  class facing_scoreboard;
    vec3_t    nrm_i, nrm_j;
    vec3_t    verts_i[MAX_VERTS];
    vec3_t    verts_j[MAX_VERTS];
    int       count_i, count_j;
    bit       dropped;
    verdict_t expected_verdicts[$];
    int       errors;

    function new();
      nrm_i    = '0;
      nrm_j    = '0;
      count_i  = 0;
      count_j  = 0;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    // sign extension to a width that holds any 3-term dot product exactly
    function logic signed [67:0] widen(coord_t c);
      return {{36{c[31]}}, c};
    endfunction

    // sign of dot(b - a, n): +1, 0 or -1
    function int dot_sign(vec3_t a, vec3_t b, vec3_t n);
      logic signed [67:0] acc;
      acc = (widen(b.x) - widen(a.x)) * widen(n.x)
          + (widen(b.y) - widen(a.y)) * widen(n.y)
          + (widen(b.z) - widen(a.z)) * widen(n.z);
      if (acc > 0) return 1;
      if (acc < 0) return -1;
      return 0;
    endfunction

    // any vertex pair that faces i and faces away from j
    function bit pair_facing();
      for (int m = 0; m < count_i; m++)
        for (int k = 0; k < count_j; k++)
          if (dot_sign(verts_i[m], verts_j[k], nrm_i) > 0 &&
              dot_sign(verts_i[m], verts_j[k], nrm_j) < 0)
            return 1'b1;
      return 1'b0;
    endfunction

    function void note_request(logic [2:0] code, vec3_t v);
      verdict_t verdict;
      case (code)
        REQ_NORMAL_I: nrm_i = v;
        REQ_NORMAL_J: nrm_j = v;
        REQ_VERT_I: begin
          if (count_i < MAX_VERTS) verts_i[count_i++] = v;
          else dropped = 1'b1;
        end
        REQ_VERT_J: begin
          if (count_j < MAX_VERTS) verts_j[count_j++] = v;
          else dropped = 1'b1;
        end
        REQ_EVAL: begin
          verdict.culled     = !pair_facing();
          verdict.overflowed = dropped;
          expected_verdicts.push_back(verdict);
          count_i = 0;
          count_j = 0;
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(logic culled, logic overflowed);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_verdicts.pop_front();
      if (culled !== want.culled)
        report($sformatf("culled got %b want %b", culled, want.culled));
      if (overflowed !== want.overflowed)
        report($sformatf("overflowed got %b want %b", overflowed, want.overflowed));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pmft_in_if  in_ch ();
  pmft_out_if out_ch ();

  polygon_mutual_facing_test_top #(
    .MAX_VERTS (MAX_VERTS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  facing_scoreboard sb = new();

  int sent_items = 0;   // accepted-to-be beats that the block acts on
  int tx_calm    = 0;   // beats left in a no-gap stretch on the input side

  // --------------------------------------------------------------------------
  // monitors: everything sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.req_type, {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.culled, out_ch.overflowed);
  end

  // --------------------------------------------------------------------------
  // input driver helpers
  // --------------------------------------------------------------------------
  function automatic vec3_t mk(coord_t x, coord_t y, coord_t z);
    return {x, y, z};
  endfunction

  // coordinate flavors: full range, tiny, extreme corners, modest Q16.16
  function automatic coord_t pick_coord(int flavor);
    case (flavor)
      0: return $urandom;
      1: return int'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 5))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 0;
          3: return 1;
          4: return -1;
          default: return 32'sh0001_0000;
        endcase
      end
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic vec3_t pick_vec(int flavor);
    return {pick_coord(flavor), pick_coord(flavor), pick_coord(flavor)};
  endfunction

  // mostly within capacity, sometimes empty, sometimes past the store size
  function automatic int pick_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll < 8) return $urandom_range(1, MAX_VERTS);
    return $urandom_range(MAX_VERTS + 1, MAX_VERTS + 2);
  endfunction

  // one input beat: random gap with valid low, then hold until ready
  task automatic send_beat(input logic [2:0] code, input vec3_t v);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 30) == 0) tx_calm = $urandom_range(10, 40);
    end
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.req_type = code;
    in_ch.coord_x  = v.x;
    in_ch.coord_y  = v.y;
    in_ch.coord_z  = v.z;
    do @(posedge clk); while (!in_ch.ready);
    if (code <= REQ_EVAL) sent_items++;
  endtask

  // polygon pair: normals (sometimes left out) and vertices in random order, then evaluate
  task automatic run_polygon_pair();
    int    flavor, shape, want_i, want_j;
    bit    need_ni, need_nj;
    vec3_t ni, nj;
    flavor = $urandom_range(0, 3);
    shape  = $urandom_range(0, 4);
    ni = pick_vec(flavor);
    case (shape)
      0: nj = pick_vec(flavor);
      1: nj = ni;                        // same facing, never visible
      2: nj = {-ni.x, -ni.y, -ni.z};     // opposite facing
      default: nj = pick_vec(flavor);
    endcase
    need_ni = (shape != 4) || $urandom_range(0, 1);
    need_nj = (shape != 4) && $urandom_range(0, 7) != 0;
    want_i  = pick_count();
    want_j  = pick_count();
    while (need_ni || need_nj || want_i > 0 || want_j > 0) begin
      case ($urandom_range(0, 3))
        0: if (need_ni) begin
          send_beat(REQ_NORMAL_I, ni);
          need_ni = 1'b0;
        end
        1: if (need_nj) begin
          send_beat(REQ_NORMAL_J, nj);
          need_nj = 1'b0;
        end
        2: if (want_i > 0) begin
          send_beat(REQ_VERT_I, pick_vec(flavor));
          want_i--;
        end
        default: if (want_j > 0) begin
          send_beat(REQ_VERT_J, pick_vec(flavor));
          want_j--;
        end
      endcase
    end
    send_beat(REQ_EVAL, pick_vec(0));
  endtask

  // noise: unused codes, stray loads and bare evaluates
  task automatic run_noise();
    int n;
    logic [2:0] code;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 1)) code = 3'($urandom_range(5, 7));
      else code = 3'($urandom_range(0, 4));
      send_beat(code, pick_vec(0));
    end
  endtask

  // --------------------------------------------------------------------------
  // result sink: random stalls, two long holds to back the block up
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall, taken, rx_calm;
    taken   = 0;
    rx_calm = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken == 12 || taken == 180) begin
        stall = LONG_HOLD;
      end else if (rx_calm > 0) begin
        rx_calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 16);
        if ($urandom_range(0, 20) == 0) rx_calm = $urandom_range(5, 20);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_NORMAL_I;
    in_ch.coord_x  = '0;
    in_ch.coord_y  = '0;
    in_ch.coord_z  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // empty polygons right after reset
    send_beat(REQ_EVAL, mk(0, 0, 0));

    // vertices but normals still at their reset value of zero
    send_beat(REQ_VERT_I, mk(1, 2, 3));
    send_beat(REQ_VERT_J, mk(5, -7, 9));
    send_beat(REQ_EVAL, mk(-1, -1, -1));

    // widest r against the extreme normals, pair is visible
    send_beat(REQ_NORMAL_I, mk(COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(REQ_NORMAL_J, mk(COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(REQ_VERT_I, mk(COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(REQ_VERT_J, mk(COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(REQ_EVAL, mk(0, 0, 0));

    // store full on i, drop flagged; coincident vertices give a zero r
    repeat (MAX_VERTS + 1) send_beat(REQ_VERT_I, mk(0, 0, 0));
    send_beat(REQ_VERT_J, mk(0, 0, 0));
    send_beat(REQ_EVAL, mk(0, 0, 0));

    // unused request codes change nothing; drop flag cleared by last evaluate
    send_beat(3'd5, mk(-1, -1, -1));
    send_beat(3'd6, mk(-1, -1, -1));
    send_beat(3'd7, mk(-1, -1, -1));
    send_beat(REQ_EVAL, mk(-1, -1, -1));

    // dot with normal j exactly zero: not facing away, so culled
    send_beat(REQ_NORMAL_I, mk(1, 0, 0));
    send_beat(REQ_NORMAL_J, mk(0, 0, -1));
    send_beat(REQ_VERT_I, mk(0, 0, 0));
    send_beat(REQ_VERT_J, mk(1, 0, 0));
    send_beat(REQ_EVAL, mk(0, 0, 0));

    // random part: mostly full pair sequences, some noise
    while (sent_items < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) run_noise();
      else run_polygon_pair();
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    // drain, then let any stray result show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
